// ===== sv/sltp_pkg.sv =====
package sltp_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] MAGIC_A  = 8'hE0;
  localparam logic [7:0] MAGIC_B  = 8'h0E;
  localparam logic [7:0] TYPE_STR = 8'h02;
  localparam logic [7:0] TYPE_U32 = 8'h03;
  localparam logic [7:0] TYPE_U16 = 8'h08;
  localparam logic [7:0] TYPE_U8  = 8'h09;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_COUNT   = 4'd1,
    PH_IP      = 4'd2,
    PH_PORT    = 4'd3,
    PH_TAGCNT  = 4'd4,
    PH_TYPE    = 4'd5,
    PH_NAMELEN = 4'd6,
    PH_NAME    = 4'd7,
    PH_STRLEN  = 4'd8,
    PH_STR     = 4'd9,
    PH_U32     = 4'd10,
    PH_U16     = 4'd11,
    PH_U8      = 4'd12,
    PH_ERROR   = 4'd13,
    PH_DONE    = 4'd14
  } phase_e;

  typedef enum logic [3:0] {
    KIND_HDR_OK   = 4'd0,
    KIND_SRV_CNT  = 4'd1,
    KIND_IP       = 4'd2,
    KIND_PORT     = 4'd3,
    KIND_TAG_CNT  = 4'd4,
    KIND_TAG_TYPE = 4'd5,
    KIND_NAME_LEN = 4'd6,
    KIND_NAME_B   = 4'd7,
    KIND_STR_LEN  = 4'd8,
    KIND_STR_B    = 4'd9,
    KIND_U32      = 4'd10,
    KIND_U16      = 4'd11,
    KIND_U8       = 4'd12,
    KIND_BAD_MAG  = 4'd13,
    KIND_BAD_TYPE = 4'd14
  } kind_e;

  // classified input beat
  typedef struct packed {
    logic [7:0] data;
    logic       file_start;
    logic       magic_ok;
    logic       type_ok;
    phase_e     type_phase;
  } item_t;

endpackage

// ===== sv/sltp_front.sv =====
module sltp_front (
  input  logic                s_tvalid_i,
  input  logic [7:0]          s_data_i,
  input  logic                s_file_start_i,
  output logic                s_tready_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output sltp_pkg::item_t     q_item_o
);

  sltp_pkg::phase_e type_phase;
  logic             type_ok;

  always_comb begin
    type_ok    = 1'b1;
    type_phase = sltp_pkg::PH_U8;
    case (s_data_i)
      sltp_pkg::TYPE_STR: type_phase = sltp_pkg::PH_STRLEN;
      sltp_pkg::TYPE_U32: type_phase = sltp_pkg::PH_U32;
      sltp_pkg::TYPE_U16: type_phase = sltp_pkg::PH_U16;
      sltp_pkg::TYPE_U8:  type_phase = sltp_pkg::PH_U8;
      default:            type_ok    = 1'b0;
    endcase
  end

  assign s_tready_o = !q_full_i;
  assign q_push_o   = s_tvalid_i && !q_full_i;

  assign q_item_o.data       = s_data_i;
  assign q_item_o.file_start = s_file_start_i;
  assign q_item_o.magic_ok   = (s_data_i == sltp_pkg::MAGIC_A) ||
                               (s_data_i == sltp_pkg::MAGIC_B);
  assign q_item_o.type_ok    = type_ok;
  assign q_item_o.type_phase = type_phase;

endmodule

// ===== sv/sltp_fifo.sv =====
module sltp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sltp_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sltp_pkg::item_t item_o
);

  sltp_pkg::item_t                  mem_q [sltp_pkg::QDEPTH];
  logic [sltp_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [sltp_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [sltp_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                             do_pop;

  assign full_o  = (cnt_q == sltp_pkg::QCNT_W'(sltp_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== sv/sltp_back.sv =====
module sltp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  sltp_pkg::item_t       q_item_i,
  output logic                  q_pop_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output sltp_pkg::kind_e       kind_o,
  output logic [31:0]           value_o,
  output logic [31:0]           server_num_o,
  output logic [31:0]           tag_num_o,
  output logic                  str_last_o,
  output logic                  file_done_o
);

  sltp_pkg::phase_e phase_q, phase_d, cur_phase;
  sltp_pkg::phase_e vphase_q, vphase_d, cur_vphase;
  logic [1:0]       pos_q, pos_d, cur_pos;
  logic [31:0]      word_q, word_d, cur_word;
  logic [31:0]      srv_left_q, srv_left_d, cur_srv_left;
  logic [31:0]      tag_left_q, tag_left_d, cur_tag_left;
  logic [15:0]      byte_left_q, byte_left_d, cur_byte_left;
  logic [31:0]      srv_idx_q, srv_idx_d, cur_srv_idx;
  logic [31:0]      tag_idx_q, tag_idx_d, cur_tag_idx;

  logic             out_valid_q, out_valid_d;
  sltp_pkg::kind_e  kind_q, kind_r;
  logic [31:0]      value_q, value_r;
  logic [31:0]      sn_q, tn_q;
  logic             last_q, last_r;
  logic             done_q, done_r;
  logic             has_res;

  logic             fs;
  logic [7:0]       b;
  logic [31:0]      acc;
  logic             full4, full2;
  logic [31:0]      tag_left_m1, srv_left_m1;
  logic [15:0]      byte_left_m1;
  logic             end_tag, end_srv;

  assign q_pop_o = q_valid_i && (!out_valid_q || m_tready_i);
  assign fs      = q_item_i.file_start;
  assign b       = q_item_i.data;

  // a file start clears the parse before this byte is looked at
  assign cur_phase     = fs ? sltp_pkg::PH_MAGIC : phase_q;
  assign cur_vphase    = fs ? sltp_pkg::PH_U8    : vphase_q;
  assign cur_pos       = fs ? 2'd0  : pos_q;
  assign cur_word      = fs ? 32'd0 : word_q;
  assign cur_srv_left  = fs ? 32'd0 : srv_left_q;
  assign cur_tag_left  = fs ? 32'd0 : tag_left_q;
  assign cur_byte_left = fs ? 16'd0 : byte_left_q;
  assign cur_srv_idx   = fs ? 32'd0 : srv_idx_q;
  assign cur_tag_idx   = fs ? 32'd0 : tag_idx_q;

  assign acc          = cur_word | ({24'd0, b} << {cur_pos, 3'b000});
  assign full4        = (cur_pos == 2'd3);
  assign full2        = (cur_pos != 2'd0);
  assign tag_left_m1  = cur_tag_left - 32'd1;
  assign srv_left_m1  = cur_srv_left - 32'd1;
  assign byte_left_m1 = cur_byte_left - 16'd1;

  always_comb begin
    phase_d     = phase_q;
    vphase_d    = vphase_q;
    pos_d       = pos_q;
    word_d      = word_q;
    srv_left_d  = srv_left_q;
    tag_left_d  = tag_left_q;
    byte_left_d = byte_left_q;
    srv_idx_d   = srv_idx_q;
    tag_idx_d   = tag_idx_q;
    has_res     = 1'b0;
    kind_r      = sltp_pkg::KIND_HDR_OK;
    value_r     = {24'd0, b};
    last_r      = 1'b0;
    done_r      = 1'b0;
    end_tag     = 1'b0;
    end_srv     = 1'b0;

    if (q_pop_o) begin
      phase_d     = cur_phase;
      vphase_d    = cur_vphase;
      pos_d       = cur_pos;
      word_d      = cur_word;
      srv_left_d  = cur_srv_left;
      tag_left_d  = cur_tag_left;
      byte_left_d = cur_byte_left;
      srv_idx_d   = cur_srv_idx;
      tag_idx_d   = cur_tag_idx;

      case (cur_phase)
        sltp_pkg::PH_MAGIC: begin
          has_res = 1'b1;
          if (q_item_i.magic_ok) begin
            kind_r  = sltp_pkg::KIND_HDR_OK;
            phase_d = sltp_pkg::PH_COUNT;
            pos_d   = 2'd0;
            word_d  = 32'd0;
          end else begin
            kind_r  = sltp_pkg::KIND_BAD_MAG;
            phase_d = sltp_pkg::PH_ERROR;
          end
        end
        sltp_pkg::PH_COUNT, sltp_pkg::PH_IP, sltp_pkg::PH_TAGCNT,
        sltp_pkg::PH_U32: begin
          if (full4) begin
            has_res = 1'b1;
            value_r = acc;
            pos_d   = 2'd0;
            word_d  = 32'd0;
            case (cur_phase)
              sltp_pkg::PH_COUNT: begin
                kind_r     = sltp_pkg::KIND_SRV_CNT;
                srv_left_d = acc;
                if (acc == 32'd0) begin
                  phase_d = sltp_pkg::PH_DONE;
                  done_r  = 1'b1;
                end else begin
                  phase_d = sltp_pkg::PH_IP;
                end
              end
              sltp_pkg::PH_IP: begin
                kind_r  = sltp_pkg::KIND_IP;
                phase_d = sltp_pkg::PH_PORT;
              end
              sltp_pkg::PH_TAGCNT: begin
                kind_r     = sltp_pkg::KIND_TAG_CNT;
                tag_left_d = acc;
                tag_idx_d  = 32'd0;
                if (acc == 32'd0) begin
                  end_srv = 1'b1;
                end else begin
                  phase_d = sltp_pkg::PH_TYPE;
                end
              end
              default: begin
                kind_r  = sltp_pkg::KIND_U32;
                end_tag = 1'b1;
              end
            endcase
          end else begin
            word_d = acc;
            pos_d  = cur_pos + 2'd1;
          end
        end
        sltp_pkg::PH_PORT, sltp_pkg::PH_NAMELEN, sltp_pkg::PH_STRLEN,
        sltp_pkg::PH_U16: begin
          if (full2) begin
            has_res = 1'b1;
            value_r = acc;
            pos_d   = 2'd0;
            word_d  = 32'd0;
            case (cur_phase)
              sltp_pkg::PH_PORT: begin
                kind_r  = sltp_pkg::KIND_PORT;
                phase_d = sltp_pkg::PH_TAGCNT;
              end
              sltp_pkg::PH_NAMELEN: begin
                kind_r = sltp_pkg::KIND_NAME_LEN;
                if (acc == 32'd0) begin
                  phase_d = cur_vphase;
                end else begin
                  byte_left_d = acc[15:0];
                  phase_d     = sltp_pkg::PH_NAME;
                end
              end
              sltp_pkg::PH_STRLEN: begin
                kind_r = sltp_pkg::KIND_STR_LEN;
                if (acc == 32'd0) begin
                  end_tag = 1'b1;
                end else begin
                  byte_left_d = acc[15:0];
                  phase_d     = sltp_pkg::PH_STR;
                end
              end
              default: begin
                kind_r  = sltp_pkg::KIND_U16;
                end_tag = 1'b1;
              end
            endcase
          end else begin
            word_d = acc;
            pos_d  = cur_pos + 2'd1;
          end
        end
        sltp_pkg::PH_TYPE: begin
          has_res = 1'b1;
          if (q_item_i.type_ok) begin
            kind_r   = sltp_pkg::KIND_TAG_TYPE;
            vphase_d = q_item_i.type_phase;
            phase_d  = sltp_pkg::PH_NAMELEN;
          end else begin
            kind_r  = sltp_pkg::KIND_BAD_TYPE;
            phase_d = sltp_pkg::PH_ERROR;
          end
        end
        sltp_pkg::PH_NAME: begin
          has_res     = 1'b1;
          kind_r      = sltp_pkg::KIND_NAME_B;
          byte_left_d = byte_left_m1;
          if (byte_left_m1 == 16'd0) begin
            last_r  = 1'b1;
            phase_d = cur_vphase;
          end
        end
        sltp_pkg::PH_STR: begin
          has_res     = 1'b1;
          kind_r      = sltp_pkg::KIND_STR_B;
          byte_left_d = byte_left_m1;
          if (byte_left_m1 == 16'd0) begin
            last_r  = 1'b1;
            end_tag = 1'b1;
          end
        end
        sltp_pkg::PH_U8: begin
          has_res = 1'b1;
          kind_r  = sltp_pkg::KIND_U8;
          end_tag = 1'b1;
        end
        default: begin
          has_res = 1'b0;
        end
      endcase

      if (end_tag) begin
        tag_left_d = tag_left_m1;
        tag_idx_d  = cur_tag_idx + 32'd1;
        if (tag_left_m1 == 32'd0) begin
          end_srv = 1'b1;
        end else begin
          phase_d = sltp_pkg::PH_TYPE;
        end
      end
      if (end_srv) begin
        srv_left_d = srv_left_m1;
        srv_idx_d  = cur_srv_idx + 32'd1;
        tag_idx_d  = 32'd0;
        if (srv_left_m1 == 32'd0) begin
          phase_d = sltp_pkg::PH_DONE;
          done_r  = 1'b1;
        end else begin
          phase_d = sltp_pkg::PH_IP;
        end
      end
    end

    out_valid_d = out_valid_q;
    if (q_pop_o && has_res) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sltp_pkg::PH_MAGIC;
      vphase_q    <= sltp_pkg::PH_U8;
      pos_q       <= 2'd0;
      word_q      <= 32'd0;
      srv_left_q  <= 32'd0;
      tag_left_q  <= 32'd0;
      byte_left_q <= 16'd0;
      srv_idx_q   <= 32'd0;
      tag_idx_q   <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      vphase_q    <= vphase_d;
      pos_q       <= pos_d;
      word_q      <= word_d;
      srv_left_q  <= srv_left_d;
      tag_left_q  <= tag_left_d;
      byte_left_q <= byte_left_d;
      srv_idx_q   <= srv_idx_d;
      tag_idx_q   <= tag_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && has_res) begin
      kind_q  <= kind_r;
      value_q <= value_r;
      sn_q    <= cur_srv_idx;
      tn_q    <= cur_tag_idx;
      last_q  <= last_r;
      done_q  <= done_r;
    end
  end

  assign m_tvalid_o   = out_valid_q;
  assign kind_o       = kind_q;
  assign value_o      = value_q;
  assign server_num_o = sn_q;
  assign tag_num_o    = tn_q;
  assign str_last_o   = last_q;
  assign file_done_o  = done_q;

endmodule

// ===== sv/server_list_tlv_parser_unit.sv =====
// An accepted byte is written into the queue, then popped and parsed; any result it gives is registered at the output.
// Throughput: one byte per cycle while the output is not stalled, set by the parse update in the back end.
// The input side stalls only when the 4-entry queue is full; the queue keeps
// taking bytes while a result waits on the output, until it fills.
// Reset (rst_ni low, asynchronous): queue emptied, parser expects a magic byte,
// all counters cleared, no result pending.
module server_list_tlv_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic          s_axis_tuser,   // [0] file_start
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] field_value, [63:32] server_number, [95:64] tag_number,
  // [96] file_done, [103:97] zero
  output logic [103:0]  m_axis_tdata,
  output logic [3:0]    m_axis_tuser,   // [3:0] field_kind
  output logic          m_axis_tlast    // string_last
);

  sltp_pkg::item_t  push_item, pop_item;
  sltp_pkg::kind_e  kind;
  logic             q_full, q_push, q_valid, q_pop;
  logic [31:0]      value, server_num, tag_num;
  logic             file_done;

  sltp_front u_front (
    .s_tvalid_i     (s_axis_tvalid),
    .s_data_i       (s_axis_tdata),
    .s_file_start_i (s_axis_tuser),
    .s_tready_o     (s_axis_tready),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (push_item)
  );

  sltp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  sltp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (pop_item),
    .q_pop_o      (q_pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .kind_o       (kind),
    .value_o      (value),
    .server_num_o (server_num),
    .tag_num_o    (tag_num),
    .str_last_o   (m_axis_tlast),
    .file_done_o  (file_done)
  );

  assign m_axis_tdata = {7'd0, file_done, tag_num, server_num, value};
  assign m_axis_tuser = kind;

endmodule

// ===== sv/sltp_checker.sv =====
module sltp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [103:0]  m_axis_tdata,
  input logic [3:0]    m_axis_tuser,
  input logic          m_axis_tlast
);

  // held beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tuser == sltp_pkg::KIND_NAME_B) ||
      (m_axis_tuser == sltp_pkg::KIND_STR_B))
    else $error("tlast on a beat that is not a name or string byte");

  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[96] |->
      (m_axis_tuser == sltp_pkg::KIND_SRV_CNT) ||
      (m_axis_tuser == sltp_pkg::KIND_TAG_CNT) ||
      (m_axis_tuser == sltp_pkg::KIND_STR_LEN) ||
      (m_axis_tuser == sltp_pkg::KIND_STR_B) ||
      (m_axis_tuser == sltp_pkg::KIND_U32) ||
      (m_axis_tuser == sltp_pkg::KIND_U16) ||
      (m_axis_tuser == sltp_pkg::KIND_U8))
    else $error("file done on a beat that cannot end a server");

  a_hdr_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == sltp_pkg::KIND_HDR_OK) |->
      ((m_axis_tdata[31:0] == 32'h0000_00E0) ||
       (m_axis_tdata[31:0] == 32'h0000_000E)) &&
      (m_axis_tdata[95:32] == 64'd0) && !m_axis_tlast && !m_axis_tdata[96])
    else $error("header beat with wrong value or indexes");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[103:97] == 7'd0) && (m_axis_tuser != 4'hF))
    else $error("padding bits or kind out of range");

endmodule

bind server_list_tlv_parser_unit sltp_checker u_sltp_checker (.*);
